FILE: hdl/kcd_pkg.sv
// Shared types, constants and helper functions for the k-core decomposition unit.
// Used by kcd_engine and kcore_decomposition_unit; depends on nothing.
package kcd_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int MAX_DEG      = 2 * MAX_EDGES;

    localparam int V_W   = 7;                            // vertex number field width
    localparam int VA_W  = $clog2(MAX_VERTICES);         // vertex table address width
    localparam int POS_W = 7;                            // position / bin start width
    localparam int DEG_W = $clog2(MAX_DEG + 1);          // degree and bin index width
    localparam int EC_W  = $clog2(MAX_EDGES + 1);        // edge count width
    localparam int EA_W  = $clog2(MAX_EDGES);            // edge store address width
    localparam int CORE_W = 9;
    localparam int CORE_MAX = 511;

    localparam logic CMD_EDGE    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    typedef struct packed {
        logic            cmd;
        logic [V_W-1:0]  end_a;
        logic [V_W-1:0]  end_b;
    } t_item;

    typedef struct packed {
        logic [V_W-1:0]    vertex;
        logic [CORE_W-1:0] core_number;
        logic              last;
        logic              edges_dropped;
    } t_result;

    typedef struct packed {
        logic [V_W-1:0] a;
        logic [V_W-1:0] b;
    } t_edge;

    // Launch of one decomposition run.
    typedef struct packed {
        logic            start;
        logic [V_W-1:0]  n;
        logic [EC_W-1:0] ec;
        logic            dropped;
    } t_run;

    // True when both endpoints lie in 1..n.
    function automatic logic edge_ok(input logic [V_W-1:0] a, input logic [V_W-1:0] b,
                                     input logic [V_W-1:0] n);
        edge_ok = (a != '0) && (a <= n) && (b != '0) && (b <= n);
    endfunction

    // Table address of vertex or position v (numbered from 1).
    function automatic logic [VA_W-1:0] vaddr(input logic [V_W-1:0] v);
        logic [V_W-1:0] t;
        t = v - V_W'(1);
        vaddr = t[VA_W-1:0];
    endfunction

endpackage

FILE: hdl/kcd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module kcd_ram #(
    parameter int DW = 8,
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hdl/kcd_engine.sv
// Decomposition sequencer: degree count, bin sort, peeling and result emission.
// Holds degree, position, order and bin start RAMs; depends on kcd_pkg and kcd_ram.
module kcd_engine (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  kcd_pkg::t_run           i_run,
    output logic [kcd_pkg::EA_W-1:0] o_edge_raddr,
    input  kcd_pkg::t_edge          i_edge,
    output logic                    o_res_vld,
    output kcd_pkg::t_result        o_res,
    output logic                    o_done
);
    typedef enum logic [4:0] {
        S_IDLE, S_CLRDEG, S_ECNT_RD, S_ECNT_A, S_ECNT_AW, S_ECNT_BR, S_ECNT_BW,
        S_BCLR, S_BCNT_RD, S_BCNT_BR, S_BCNT_W, S_PFX_RD, S_PFX_W,
        S_PLC_RD, S_PLC_BR, S_PLC_W, S_SHF_RD, S_SHF_W, S_SHF0,
        S_PEEL_RD, S_PEEL_X, S_PEEL_DX, S_PE_RD, S_PE_CHK,
        S_L1, S_L2, S_L3, S_L4, S_L5, S_OUT_RD, S_OUT_EM
    } t_state;

    localparam int V_W = kcd_pkg::V_W;
    localparam int VA_W = kcd_pkg::VA_W;
    localparam int P_W = kcd_pkg::POS_W;
    localparam int D_W = kcd_pkg::DEG_W;
    localparam int EC_W = kcd_pkg::EC_W;

    t_state r_st;
    logic [V_W-1:0]  r_n, r_i, r_a, r_b, r_x, r_u, r_pu, r_pw, r_start;
    logic [EC_W-1:0] r_ec, r_e;
    logic [D_W-1:0]  r_d, r_md, r_dx, r_du;
    logic            r_drop, r_pend;

    logic            deg_we, pos_we, ord_we, bin_we;
    logic [VA_W-1:0] deg_wa, deg_ra, pos_wa, pos_ra, ord_wa, ord_ra;
    logic [D_W-1:0]  deg_wd, deg_q, bin_wa, bin_ra;
    logic [P_W-1:0]  pos_wd, pos_q, ord_wd, ord_q, bin_wd, bin_q;
    logic [D_W-1:0]  deg_inc;
    logic            edge_last, vert_last;

    assign deg_inc   = deg_q + D_W'(1);
    assign edge_last = (r_e + EC_W'(1)) == r_ec;
    assign vert_last = r_i == r_n;
    assign o_edge_raddr = r_e[kcd_pkg::EA_W-1:0];

    kcd_ram #(.DW(D_W), .AW(VA_W)) u_deg (.i_clk, .i_we(deg_we), .i_waddr(deg_wa),
        .i_wdata(deg_wd), .i_raddr(deg_ra), .o_rdata(deg_q));
    kcd_ram #(.DW(P_W), .AW(VA_W)) u_pos (.i_clk, .i_we(pos_we), .i_waddr(pos_wa),
        .i_wdata(pos_wd), .i_raddr(pos_ra), .o_rdata(pos_q));
    kcd_ram #(.DW(P_W), .AW(VA_W)) u_ord (.i_clk, .i_we(ord_we), .i_waddr(ord_wa),
        .i_wdata(ord_wd), .i_raddr(ord_ra), .o_rdata(ord_q));
    kcd_ram #(.DW(P_W), .AW(D_W)) u_bin (.i_clk, .i_we(bin_we), .i_waddr(bin_wa),
        .i_wdata(bin_wd), .i_raddr(bin_ra), .o_rdata(bin_q));

    // Memory port control.
    always_comb begin
        deg_we = 1'b0; deg_wa = '0; deg_wd = '0; deg_ra = '0;
        pos_we = 1'b0; pos_wa = '0; pos_wd = '0; pos_ra = '0;
        ord_we = 1'b0; ord_wa = '0; ord_wd = '0; ord_ra = '0;
        bin_we = 1'b0; bin_wa = '0; bin_wd = '0; bin_ra = '0;
        unique case (r_st)
            S_CLRDEG: begin
                deg_we = 1'b1; deg_wa = kcd_pkg::vaddr(r_i);
            end
            S_ECNT_A:  deg_ra = kcd_pkg::vaddr(i_edge.a);
            S_ECNT_AW: begin
                deg_we = 1'b1; deg_wa = kcd_pkg::vaddr(r_a); deg_wd = deg_inc;
            end
            S_ECNT_BR: deg_ra = kcd_pkg::vaddr(r_b);
            S_ECNT_BW: begin
                deg_we = 1'b1; deg_wa = kcd_pkg::vaddr(r_b); deg_wd = deg_inc;
            end
            S_BCLR: begin
                bin_we = 1'b1; bin_wa = r_d;
            end
            S_BCNT_RD, S_PLC_RD, S_OUT_RD: deg_ra = kcd_pkg::vaddr(r_i);
            S_BCNT_BR, S_PLC_BR: bin_ra = deg_q;
            S_BCNT_W: begin
                bin_we = 1'b1; bin_wa = r_du; bin_wd = bin_q + P_W'(1);
            end
            S_PFX_RD: bin_ra = r_d;
            S_PFX_W: begin
                bin_we = 1'b1; bin_wa = r_d; bin_wd = r_start;
            end
            S_PLC_W: begin
                pos_we = 1'b1; pos_wa = kcd_pkg::vaddr(r_i); pos_wd = bin_q;
                ord_we = 1'b1; ord_wa = kcd_pkg::vaddr(bin_q); ord_wd = r_i;
                bin_we = 1'b1; bin_wa = r_du; bin_wd = bin_q + P_W'(1);
            end
            S_SHF_RD: bin_ra = r_d - D_W'(1);
            S_SHF_W: begin
                bin_we = 1'b1; bin_wa = r_d; bin_wd = bin_q;
            end
            S_SHF0: begin
                bin_we = 1'b1; bin_wa = '0; bin_wd = P_W'(1);
            end
            S_PEEL_RD: ord_ra = kcd_pkg::vaddr(r_i);
            S_PEEL_X:  deg_ra = kcd_pkg::vaddr(ord_q);
            S_L1: begin
                deg_ra = kcd_pkg::vaddr(r_u); pos_ra = kcd_pkg::vaddr(r_u);
            end
            S_L2: bin_ra = deg_q;
            S_L3: ord_ra = kcd_pkg::vaddr(bin_q);
            S_L4: begin
                bin_we = 1'b1; bin_wa = r_du; bin_wd = r_pw + P_W'(1);
                deg_we = 1'b1; deg_wa = kcd_pkg::vaddr(r_u); deg_wd = r_du - D_W'(1);
                pos_we = 1'b1; pos_wa = kcd_pkg::vaddr(r_u); pos_wd = r_pw;
                ord_we = 1'b1; ord_wa = kcd_pkg::vaddr(r_pu); ord_wd = ord_q;
            end
            S_L5: begin
                pos_we = 1'b1; pos_wa = kcd_pkg::vaddr(r_b); pos_wd = r_pu;
                ord_we = 1'b1; ord_wa = kcd_pkg::vaddr(r_pw); ord_wd = r_u;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            o_res_vld <= 1'b0;
            o_done    <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            o_res_vld <= (r_st == S_OUT_EM);
            o_done    <= ((r_st == S_IDLE) && i_run.start && (i_run.n == '0)) ||
                         ((r_st == S_OUT_EM) && vert_last);
            unique case (r_st)
                S_IDLE: begin
                    if (i_run.start) begin
                        r_n    <= i_run.n;
                        r_ec   <= i_run.ec;
                        r_drop <= i_run.dropped;
                        r_md   <= '0;
                        r_i    <= V_W'(1);
                        r_e    <= '0;
                        if (i_run.n != '0) begin
                            r_st <= S_CLRDEG;
                        end
                    end
                end
                S_CLRDEG: begin
                    r_i <= r_i + V_W'(1);
                    if (vert_last) begin
                        r_d  <= '0;
                        r_st <= (r_ec == '0) ? S_BCLR : S_ECNT_RD;
                    end
                end
                S_ECNT_RD: r_st <= S_ECNT_A;
                S_ECNT_A: begin
                    r_a <= i_edge.a;
                    r_b <= i_edge.b;
                    if (kcd_pkg::edge_ok(i_edge.a, i_edge.b, r_n)) begin
                        r_st <= S_ECNT_AW;
                    end else begin
                        r_e  <= r_e + EC_W'(1);
                        r_st <= edge_last ? S_BCLR : S_ECNT_RD;
                    end
                end
                S_ECNT_AW: begin
                    if (deg_inc > r_md) r_md <= deg_inc;
                    r_st <= S_ECNT_BR;
                end
                S_ECNT_BR: r_st <= S_ECNT_BW;
                S_ECNT_BW: begin
                    if (deg_inc > r_md) r_md <= deg_inc;
                    r_e  <= r_e + EC_W'(1);
                    r_st <= edge_last ? S_BCLR : S_ECNT_RD;
                end
                S_BCLR: begin
                    r_d <= r_d + D_W'(1);
                    if (r_d == r_md) begin
                        r_i  <= V_W'(1);
                        r_st <= S_BCNT_RD;
                    end
                end
                S_BCNT_RD: r_st <= S_BCNT_BR;
                S_BCNT_BR: begin
                    r_du <= deg_q;
                    r_st <= S_BCNT_W;
                end
                S_BCNT_W: begin
                    r_i <= r_i + V_W'(1);
                    if (vert_last) begin
                        r_d     <= '0;
                        r_start <= V_W'(1);
                        r_st    <= S_PFX_RD;
                    end else begin
                        r_st <= S_BCNT_RD;
                    end
                end
                S_PFX_RD: r_st <= S_PFX_W;
                S_PFX_W: begin
                    r_start <= r_start + bin_q;
                    r_d     <= r_d + D_W'(1);
                    if (r_d == r_md) begin
                        r_i  <= V_W'(1);
                        r_st <= S_PLC_RD;
                    end else begin
                        r_st <= S_PFX_RD;
                    end
                end
                S_PLC_RD: r_st <= S_PLC_BR;
                S_PLC_BR: begin
                    r_du <= deg_q;
                    r_st <= S_PLC_W;
                end
                S_PLC_W: begin
                    r_i <= r_i + V_W'(1);
                    if (vert_last) begin
                        r_d  <= r_md;
                        r_st <= (r_md == '0) ? S_SHF0 : S_SHF_RD;
                    end else begin
                        r_st <= S_PLC_RD;
                    end
                end
                S_SHF_RD: r_st <= S_SHF_W;
                S_SHF_W: begin
                    r_d  <= r_d - D_W'(1);
                    r_st <= (r_d == D_W'(1)) ? S_SHF0 : S_SHF_RD;
                end
                S_SHF0: begin
                    r_i  <= V_W'(1);
                    r_st <= S_PEEL_RD;
                end
                S_PEEL_RD: r_st <= S_PEEL_X;
                S_PEEL_X: begin
                    r_x  <= ord_q;
                    r_st <= S_PEEL_DX;
                end
                S_PEEL_DX: begin
                    r_dx <= deg_q;
                    r_e  <= '0;
                    if (r_ec != '0) begin
                        r_st <= S_PE_RD;
                    end else begin
                        r_i  <= vert_last ? V_W'(1) : r_i + V_W'(1);
                        r_st <= vert_last ? S_OUT_RD : S_PEEL_RD;
                    end
                end
                S_PE_RD: r_st <= S_PE_CHK;
                S_PE_CHK: begin
                    r_a <= i_edge.a;
                    if (kcd_pkg::edge_ok(i_edge.a, i_edge.b, r_n) && i_edge.a == r_x) begin
                        r_u    <= i_edge.b;
                        r_pend <= i_edge.b == r_x;
                        r_st   <= S_L1;
                    end else if (kcd_pkg::edge_ok(i_edge.a, i_edge.b, r_n) &&
                                 i_edge.b == r_x) begin
                        r_u    <= i_edge.a;
                        r_pend <= 1'b0;
                        r_st   <= S_L1;
                    end else begin
                        r_e <= r_e + EC_W'(1);
                        if (edge_last) begin
                            r_i  <= vert_last ? V_W'(1) : r_i + V_W'(1);
                            r_st <= vert_last ? S_OUT_RD : S_PEEL_RD;
                        end else begin
                            r_st <= S_PE_RD;
                        end
                    end
                end
                S_L1: r_st <= S_L2;
                S_L2: begin
                    r_du <= deg_q;
                    r_pu <= pos_q;
                    if (deg_q > r_dx) begin
                        r_st <= S_L3;
                    end else if (r_pend) begin
                        r_pend <= 1'b0;
                        r_u    <= r_a;
                        r_st   <= S_L1;
                    end else begin
                        r_e <= r_e + EC_W'(1);
                        if (edge_last) begin
                            r_i  <= vert_last ? V_W'(1) : r_i + V_W'(1);
                            r_st <= vert_last ? S_OUT_RD : S_PEEL_RD;
                        end else begin
                            r_st <= S_PE_RD;
                        end
                    end
                end
                S_L3: begin
                    r_pw <= bin_q;
                    r_st <= S_L4;
                end
                S_L4: begin
                    // r_b carries the vertex w that sat at the bin start.
                    r_b  <= ord_q;
                    r_st <= S_L5;
                end
                S_L5: begin
                    if (r_pend) begin
                        r_pend <= 1'b0;
                        r_u    <= r_a;
                        r_st   <= S_L1;
                    end else begin
                        r_e <= r_e + EC_W'(1);
                        if (edge_last) begin
                            r_i  <= vert_last ? V_W'(1) : r_i + V_W'(1);
                            r_st <= vert_last ? S_OUT_RD : S_PEEL_RD;
                        end else begin
                            r_st <= S_PE_RD;
                        end
                    end
                end
                S_OUT_RD: r_st <= S_OUT_EM;
                S_OUT_EM: begin
                    o_res.vertex        <= r_i;
                    o_res.core_number   <= (deg_q > D_W'(kcd_pkg::CORE_MAX)) ?
                                           kcd_pkg::CORE_W'(kcd_pkg::CORE_MAX) :
                                           deg_q[kcd_pkg::CORE_W-1:0];
                    o_res.last          <= vert_last;
                    o_res.edges_dropped <= r_drop;
                    r_i <= r_i + V_W'(1);
                    if (vert_last) begin
                        r_st <= S_IDLE;
                    end else begin
                        r_st <= S_OUT_RD;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: hdl/kcore_decomposition_unit.sv
// Top level of the k-core decomposition unit: edge store, item intake and configuration.
// Depends on kcd_pkg, kcd_ram and kcd_engine.
//
// Usage. Items arrive on i_item and are taken at a rising edge where start is high
// and busy is low. An edge item (cmd 0) leaves busy low, so edges can be streamed
// one per cycle. An edge with an endpoint outside 1..vertex_count (capped at 64),
// or one arriving with the edge store full, is dropped and remembered for the
// edges_dropped field of the next results.
// A compute item (cmd 1) raises busy. The engine clears the degree table, walks
// the edge store to count degrees, bin-sorts the vertices, then peels them in
// order, walking the whole edge store once per vertex. It then emits one result
// per vertex, 1 up to vertex_count, on o_result with o_valid high for one cycle,
// last marked. The receiver cannot stall: each result is taken in the cycle it is shown.
// Busy falls right after the last result, and the edge store and drop flag are
// empty again for the next graph.
// A vertex_count of zero gives no results and a busy pulse of one cycle.
// The vertex count register is written by i_cfg_we; the user must write it
// only while the unit is idle, as the block itself does not enforce this.
// Reset empties the edge store, clears the drop flag and sets vertex_count to 64.
module kcore_decomposition_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  kcd_pkg::t_item          i_item,
    input  logic                    i_cfg_we,
    input  logic [kcd_pkg::V_W-1:0] i_cfg_data,
    output logic                    o_valid,
    output kcd_pkg::t_result        o_result
);
    localparam int V_W = kcd_pkg::V_W;
    localparam int EC_W = kcd_pkg::EC_W;

    logic [V_W-1:0]  r_vcount;
    logic [EC_W-1:0] r_ec;
    logic            r_drop, r_busy;
    logic [V_W-1:0]  n_eff;
    logic            take, take_edge, store_ok, eng_done;
    kcd_pkg::t_run   run;
    kcd_pkg::t_edge  edge_q, edge_wd;
    logic [kcd_pkg::EA_W-1:0] edge_ra;

    // Counts above the table size act as the table size.
    assign n_eff = (r_vcount > V_W'(kcd_pkg::MAX_VERTICES)) ?
                   V_W'(kcd_pkg::MAX_VERTICES) : r_vcount;

    assign busy      = r_busy;
    assign take      = start && !r_busy;
    assign take_edge = take && (i_item.cmd == kcd_pkg::CMD_EDGE);
    assign store_ok  = kcd_pkg::edge_ok(i_item.end_a, i_item.end_b, n_eff) &&
                       (r_ec < EC_W'(kcd_pkg::MAX_EDGES));

    assign edge_wd.a = i_item.end_a;
    assign edge_wd.b = i_item.end_b;

    assign run.start   = take && (i_item.cmd == kcd_pkg::CMD_COMPUTE);
    assign run.n       = n_eff;
    assign run.ec      = r_ec;
    assign run.dropped = r_drop;

    kcd_ram #(.DW($bits(kcd_pkg::t_edge)), .AW(kcd_pkg::EA_W)) u_edges (
        .i_clk,
        .i_we    (take_edge && store_ok),
        .i_waddr (r_ec[kcd_pkg::EA_W-1:0]),
        .i_wdata (edge_wd),
        .i_raddr (edge_ra),
        .o_rdata (edge_q)
    );

    kcd_engine u_engine (
        .i_clk,
        .i_rst_n,
        .i_run        (run),
        .o_edge_raddr (edge_ra),
        .i_edge       (edge_q),
        .o_res_vld    (o_valid),
        .o_res        (o_result),
        .o_done       (eng_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= V_W'(kcd_pkg::MAX_VERTICES);
            r_ec     <= '0;
            r_drop   <= 1'b0;
            r_busy   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end
            if (run.start) begin
                r_busy <= 1'b1;
            end else if (eng_done) begin
                // Results are out: the store is emptied for the next graph.
                r_busy <= 1'b0;
                r_ec   <= '0;
                r_drop <= 1'b0;
            end else if (take_edge) begin
                if (store_ok) begin
                    r_ec <= r_ec + EC_W'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
        end
    end

    a_res_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_busy)
        else $error("result shown while the unit is idle");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |=> (!r_busy && r_ec == '0 && !r_drop))
        else $error("unit not released after the last result");

    a_store_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ec <= EC_W'(kcd_pkg::MAX_EDGES))
        else $error("edge count beyond store size");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> ($stable(r_ec) || r_ec == '0))
        else $error("edge store changed during a run");
endmodule

FILE: tb/sv/tb_kcore_decomposition_unit.sv
// Self-checking testbench for kcore_decomposition_unit: directed table plus random graphs.
// Depends on kcd_pkg and the unit's RTL; core numbers are predicted by a local peeling model.
module tb_kcore_decomposition_unit;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int ITEM_BUDGET  = 330;

    typedef enum int { ROW_CFG, ROW_ITEM } t_row_kind;

    // One row of the directed table. A compute row may carry a hand-typed core
    // number and drop flag; a negative core means the predictor decides.
    typedef struct {
        t_row_kind       kind;
        int              value;
        kcd_pkg::t_item  item;
        int              core;
        int              drop;
    } t_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    kcd_pkg::t_item            i_item;
    logic                      i_cfg_we;
    logic [kcd_pkg::V_W-1:0]   i_cfg_data;
    logic                      o_valid;
    kcd_pkg::t_result          o_result;

    // Model of the unit's visible state.
    int               vcount;
    int               edge_a [kcd_pkg::MAX_EDGES];
    int               edge_b [kcd_pkg::MAX_EDGES];
    int               edge_total;
    bit               dropped;

    kcd_pkg::t_result pending_cores[$];
    int               mismatches = 0;
    int               cycles = 0;
    int               accepted;
    bit               no_gaps;

    kcore_decomposition_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // The run is cut off well past the slowest legal schedule.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Results cannot be held off, so every strobe is compared with the oldest
    // expected core number at the edge that ends its cycle.
    always @(posedge i_clk) begin
        kcd_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_cores.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: vertex %0d core %0d",
                             o_result.vertex, o_result.core_number);
            end else begin
                want = pending_cores.pop_front();
                if (o_result !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: exp v%0d c%0d l%0b d%0b, got v%0d c%0d l%0b d%0b",
                                 want.vertex, want.core_number, want.last,
                                 want.edges_dropped, o_result.vertex,
                                 o_result.core_number, o_result.last,
                                 o_result.edges_dropped);
                end
            end
        end
    end

    function automatic int live_count();
        return (vcount > kcd_pkg::MAX_VERTICES) ? kcd_pkg::MAX_VERTICES : vcount;
    endfunction

    // Batagelj-Zaversnik peeling over the stored edges. The core numbers are
    // queued as expectations, then the store and drop flag are emptied.
    function automatic void peel_cores();
        int n;
        int deg [0:kcd_pkg::MAX_VERTICES];
        int pos [0:kcd_pkg::MAX_VERTICES];
        int ord [0:kcd_pkg::MAX_VERTICES];
        int bin [0:kcd_pkg::MAX_DEG+1];
        int maxdeg;
        int first;
        int num;
        int x;
        int a;
        int b;
        int u;
        int du;
        int pu;
        int pw;
        int w;
        kcd_pkg::t_result r;
        n = live_count();
        maxdeg = 0;
        first = 1;
        for (int i = 0; i <= n; i++) deg[i] = 0;
        for (int e = 0; e < edge_total; e++) begin
            a = edge_a[e];
            b = edge_b[e];
            if (a >= 1 && a <= n && b >= 1 && b <= n) begin
                deg[a]++;
                deg[b]++;
            end
        end
        for (int i = 1; i <= n; i++) if (deg[i] > maxdeg) maxdeg = deg[i];
        for (int d = 0; d <= maxdeg; d++) bin[d] = 0;
        for (int i = 1; i <= n; i++) bin[deg[i]]++;
        for (int d = 0; d <= maxdeg; d++) begin
            num = bin[d];
            bin[d] = first;
            first += num;
        end
        for (int i = 1; i <= n; i++) begin
            pos[i] = bin[deg[i]];
            ord[pos[i]] = i;
            bin[deg[i]]++;
        end
        for (int d = maxdeg; d > 0; d--) bin[d] = bin[d-1];
        bin[0] = 1;
        for (int i = 1; i <= n; i++) begin
            x = ord[i];
            for (int e = 0; e < edge_total; e++) begin
                a = edge_a[e];
                b = edge_b[e];
                if (a >= 1 && a <= n && b >= 1 && b <= n) begin
                    for (int side = 0; side < 2; side++) begin
                        // A neighbor of higher degree moves down one bin.
                        u = (side == 0) ? b : a;
                        if (((side == 0) ? a : b) == x && deg[u] > deg[x]) begin
                            du = deg[u];
                            pu = pos[u];
                            pw = bin[du];
                            w = ord[pw];
                            if (u != w) begin
                                pos[u] = pw;
                                ord[pu] = w;
                                pos[w] = pu;
                                ord[pw] = u;
                            end
                            bin[du]++;
                            deg[u]--;
                        end
                    end
                end
            end
        end
        for (int i = 1; i <= n; i++) begin
            r.vertex = kcd_pkg::V_W'(i);
            r.core_number = (deg[i] > kcd_pkg::CORE_MAX) ?
                            kcd_pkg::CORE_W'(kcd_pkg::CORE_MAX) :
                            kcd_pkg::CORE_W'(deg[i]);
            r.last = (i == n);
            r.edges_dropped = dropped;
            pending_cores = {pending_cores, r};
        end
        edge_total = 0;
        dropped = 1'b0;
    endfunction

    function automatic void absorb(kcd_pkg::t_item it);
        int n;
        n = live_count();
        if (it.cmd == kcd_pkg::CMD_COMPUTE) begin
            peel_cores();
        end else if (it.end_a < 1 || it.end_a > n || it.end_b < 1 || it.end_b > n ||
                     edge_total >= kcd_pkg::MAX_EDGES) begin
            dropped = 1'b1;
        end else begin
            edge_a[edge_total] = it.end_a;
            edge_b[edge_total] = it.end_b;
            edge_total++;
        end
    endfunction

    // Offers one item after a random gap and holds it until busy is low at an
    // edge. Start stays high when the next item follows with no gap.
    task automatic offer(kcd_pkg::t_item it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        absorb(it);
        accepted++;
    endtask

    // Waits until every core number has come out and the engine is idle.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_cores.size() != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_count(int value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= kcd_pkg::V_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        vcount = value;
    endtask

    function automatic kcd_pkg::t_item make_edge(int a, int b);
        kcd_pkg::t_item it;
        it.cmd = kcd_pkg::CMD_EDGE;
        it.end_a = kcd_pkg::V_W'(a);
        it.end_b = kcd_pkg::V_W'(b);
        return it;
    endfunction

    function automatic kcd_pkg::t_item make_compute();
        kcd_pkg::t_item it;
        it.cmd = kcd_pkg::CMD_COMPUTE;
        it.end_a = kcd_pkg::V_W'($urandom);
        it.end_b = kcd_pkg::V_W'($urandom);
        return it;
    endfunction

    function automatic t_row cfg_row(int value);
        t_row r;
        r.kind = ROW_CFG;
        r.value = value;
        r.item = make_edge(0, 0);
        r.core = -1;
        r.drop = 0;
        return r;
    endfunction

    function automatic t_row item_row(kcd_pkg::t_item it, int core, int drop);
        t_row r;
        r.kind = ROW_ITEM;
        r.value = 0;
        r.item = it;
        r.core = core;
        r.drop = drop;
        return r;
    endfunction

    initial begin
        t_row rows[$];
        int base;
        int n;
        int ecount;
        int a;
        int b;
        kcd_pkg::t_item it;

        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        accepted = 0;
        no_gaps = 1'b0;
        vcount = 64;
        edge_total = 0;
        dropped = 1'b0;

        // Reset leaves 64 vertices and an empty store: every core is zero.
        rows = {rows, item_row(make_compute(), 0, 0)};
        // A triangle with a pendant vertex.
        rows = {rows, cfg_row(4)};
        rows = {rows, item_row(make_edge(1, 2), -1, 0)};
        rows = {rows, item_row(make_edge(2, 3), -1, 0)};
        rows = {rows, item_row(make_edge(3, 1), -1, 0)};
        rows = {rows, item_row(make_edge(1, 4), -1, 0)};
        rows = {rows, item_row(make_compute(), -1, 0)};
        // Endpoints of zero or past the count are dropped and flagged.
        rows = {rows, item_row(make_edge(0, 1), -1, 0)};
        rows = {rows, item_row(make_edge(5, 1), -1, 0)};
        rows = {rows, item_row(make_edge(127, 127), -1, 0)};
        rows = {rows, item_row(make_compute(), 0, 1)};
        // A self-loop and a pair of parallel edges.
        rows = {rows, cfg_row(3)};
        rows = {rows, item_row(make_edge(2, 2), -1, 0)};
        rows = {rows, item_row(make_edge(1, 3), -1, 0)};
        rows = {rows, item_row(make_edge(1, 3), -1, 0)};
        rows = {rows, item_row(make_compute(), -1, 0)};
        // A count above the vertex limit acts as the limit.
        rows = {rows, cfg_row(127)};
        rows = {rows, item_row(make_edge(64, 64), -1, 0)};
        rows = {rows, item_row(make_edge(64, 1), -1, 0)};
        rows = {rows, item_row(make_compute(), -1, 0)};
        // A count of zero gives no results but still empties the store.
        rows = {rows, cfg_row(0)};
        rows = {rows, item_row(make_compute(), -1, 0)};
        // Lowering the count after loading hides edges without flagging them.
        rows = {rows, cfg_row(8)};
        rows = {rows, item_row(make_edge(8, 7), -1, 0)};
        rows = {rows, item_row(make_edge(1, 2), -1, 0)};
        rows = {rows, cfg_row(2)};
        rows = {rows, item_row(make_compute(), -1, 0)};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                write_count(rows[i].value);
            end else begin
                base = pending_cores.size();
                offer(rows[i].item);
                if (rows[i].core >= 0)
                    for (int k = base; k < pending_cores.size(); k++) begin
                        pending_cores[k].core_number = kcd_pkg::CORE_W'(rows[i].core);
                        pending_cores[k].edges_dropped = rows[i].drop[0];
                    end
            end
        end

        // Fill the store with self-loops on one vertex: the overflow is
        // flagged and a degree of 512 saturates the core number.
        write_count(1);
        no_gaps = 1'b1;
        for (int k = 0; k < kcd_pkg::MAX_EDGES + 2; k++) offer(make_edge(1, 1));
        offer(make_compute());

        // Random graphs: mostly small, well-formed edge lists with some noise.
        while (accepted < ITEM_BUDGET) begin
            case ($urandom_range(0, 9))
                0:       write_count($urandom_range(17, 127));
                1:       write_count($urandom_range(0, 2));
                default: write_count($urandom_range(1, 16));
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            n = live_count();
            ecount = $urandom_range(0, 30);
            for (int k = 0; k < ecount; k++) begin
                if (n == 0 || $urandom_range(0, 9) == 0) begin
                    a = $urandom_range(0, 127);
                    b = $urandom_range(0, 127);
                end else begin
                    a = $urandom_range(1, n);
                    b = $urandom_range(1, n);
                end
                offer(make_edge(a, b));
            end
            if (n > 1 && $urandom_range(0, 9) == 0) write_count($urandom_range(1, n - 1));
            it = make_compute();
            offer(it);
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
